/* hdl/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the C token span classifier: span classes,
// the result beat layout and the C keyword table.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Span classes
  localparam logic [2:0] ClsText    = 3'd0;
  localparam logic [2:0] ClsComment = 3'd1;
  localparam logic [2:0] ClsString  = 3'd2;
  localparam logic [2:0] ClsKeyword = 3'd3;
  localparam logic [2:0] ClsFunc    = 3'd4;
  localparam logic [2:0] ClsNumber  = 3'd5;
  localparam logic [2:0] ClsOp      = 3'd6;

  localparam int unsigned KwBytes  = 8;
  localparam int unsigned KwCount  = 29;
  localparam int unsigned FifoDepth = 4;

  typedef struct packed {
    logic [2:0] token_class;
    logic [7:0] span_length;
    logic       line_done;
  } tsc_result_t;

  // Keywords zero padded, first character in the low byte
  localparam logic [63:0] KwTable [KwCount] = '{
    64'h0000_0000_0000_6669, // if
    64'h0000_0000_6573_6c65, // else
    64'h0000_0000_0072_6f66, // for
    64'h0000_0065_6c69_6877, // while
    64'h0000_0000_0000_6f64, // do
    64'h0000_6863_7469_7773, // switch
    64'h0000_0000_6573_6163, // case
    64'h0000_6e72_7574_6572, // return
    64'h0000_006b_6165_7262, // break
    64'h6575_6e69_746e_6f63, // continue
    64'h0000_0000_6f74_6f67, // goto
    64'h0074_6c75_6166_6564, // default
    64'h0000_0000_0074_6e69, // int
    64'h0000_0000_7261_6863, // char
    64'h0000_0074_616f_6c66, // float
    64'h0000_656c_6275_6f64, // double
    64'h0000_0000_6469_6f76, // void
    64'h0000_0000_676e_6f6c, // long
    64'h0000_0074_726f_6873, // short
    64'h0000_7463_7572_7473, // struct
    64'h0000_0000_6d75_6e65, // enum
    64'h0000_006e_6f69_6e75, // union
    64'h0066_6564_6570_7974, // typedef
    64'h0000_666f_657a_6973, // sizeof
    64'h0000_0074_736e_6f63, // const
    64'h0000_6369_7461_7473, // static
    64'h0000_6e72_6574_7865, // extern
    64'h7265_7473_6967_6572, // register
    64'h656c_6974_616c_6f76  // volatile
  };

  function automatic logic kw_match(input logic [63:0] word);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < KwCount; k++) begin
      if (word == KwTable[k]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* hdl/c_token_span_classifier.sv */
// ----------------------------------------------------------------------------
// c_token_span_classifier
// Splits a C source line, one byte per beat plus an end-of-line beat, into
// classified spans (text, comment, string, keyword, function, number, op).
// ----------------------------------------------------------------------------
// Output: a span is written into the result queue on the beat that closes it;
//   a beat that closes a span and is an operator gives two spans.
// Throughput: one input beat per cycle; the output drains one span per cycle
//   unless stalled, out of a four-entry queue, and input stalls while fewer
//   than two slots are free.
// Reset: asynchronous, clears lexer state and empties the queue.
module c_token_span_classifier #(
  parameter int unsigned LINE_MAX = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_class_o,
  output logic [7:0] span_length_o,
  output logic       line_done_o
);

  tsc_pkg::tsc_result_t res0, res1, head;
  logic [1:0] res_cnt;
  logic       step;
  logic       full;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  tsc_lexer #(
    .LINE_MAX(LINE_MAX)
  ) u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .source_byte_i (source_byte_i),
    .line_end_i    (line_end_i),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  tsc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (step ? res_cnt : 2'd0),
    .push0_i     (res0),
    .push1_i     (res1),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign token_class_o = head.token_class;
  assign span_length_o = head.span_length;
  assign line_done_o   = head.line_done;

endmodule

/* hdl/tsc_lexer.sv */
// ----------------------------------------------------------------------------
// tsc_lexer
// Lexer state and single-pass step logic: one byte or end-of-line per beat,
// up to two classified spans out in the same cycle.
// ----------------------------------------------------------------------------
module tsc_lexer #(
  parameter int unsigned LINE_MAX = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          source_byte_i,
  input  logic                line_end_i,
  output tsc_pkg::tsc_result_t res0_o,
  output tsc_pkg::tsc_result_t res1_o,
  output logic [1:0]          res_cnt_o
);

  localparam int unsigned RUN_W = $clog2(LINE_MAX + 1);
  localparam logic [RUN_W-1:0] RunMax = RUN_W'(LINE_MAX);
  localparam logic [RUN_W-1:0] RunKw  = RUN_W'(tsc_pkg::KwBytes);

  localparam logic [2:0] ModeIdle  = 3'd0;
  localparam logic [2:0] ModeText  = 3'd1;
  localparam logic [2:0] ModeWord  = 3'd2;
  localparam logic [2:0] ModeNum   = 3'd3;
  localparam logic [2:0] ModeStr   = 3'd4;
  localparam logic [2:0] ModeChr   = 3'd5;
  localparam logic [2:0] ModeSlash = 3'd6;
  localparam logic [2:0] ModeCmt   = 3'd7;

  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChParen  = 8'h28;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChUscore = 8'h5f;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == 8'h3d || c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h25 ||
           c == 8'h26 || c == 8'h7c || c == 8'h3c || c == 8'h3e || c == 8'h21;
  endfunction

  function automatic logic [7:0] sat8(input logic [RUN_W-1:0] r);
    logic [RUN_W+7:0] ext;
    ext = {8'd0, r};
    return (ext > (RUN_W + 8)'(255)) ? 8'hff : ext[7:0];
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [63:0]      prefix_q, prefix_d;
  logic             esc_q, esc_d;

  logic [RUN_W-1:0] run_grow;
  logic             is_kw;
  logic [2:0]       st_mode;
  logic             st_op;
  logic             use_start;
  logic             close_v;
  tsc_pkg::tsc_result_t close_r, op_r;
  logic [7:0]       c;

  always_comb begin
    c        = source_byte_i;
    run_grow = (run_q == RunMax) ? run_q : run_q + 1'b1;
    is_kw    = (run_q <= RunKw) && tsc_pkg::kw_match(prefix_q);

    // what a fresh span opens with
    st_op = 1'b0;
    if (c == ChSlash)       st_mode = ModeSlash;
    else if (c == ChDquote) st_mode = ModeStr;
    else if (c == ChSquote) st_mode = ModeChr;
    else if (is_alpha(c))   st_mode = ModeWord;
    else if (is_digit(c))   st_mode = ModeNum;
    else if (is_op(c)) begin
      st_mode = ModeIdle;
      st_op   = 1'b1;
    end else                st_mode = ModeText;

    mode_d    = mode_q;
    run_d     = run_q;
    prefix_d  = prefix_q;
    esc_d     = esc_q;
    use_start = 1'b0;
    close_v   = 1'b0;
    close_r.token_class = tsc_pkg::ClsText;
    close_r.span_length = sat8(run_q);
    close_r.line_done   = 1'b0;

    if (line_end_i) begin
      close_v = 1'b1;
      close_r.line_done = 1'b1;
      unique case (mode_q) inside
        ModeText:          close_r.token_class = tsc_pkg::ClsText;
        ModeWord:          close_r.token_class = is_kw ? tsc_pkg::ClsKeyword
                                                       : tsc_pkg::ClsText;
        ModeNum:           close_r.token_class = tsc_pkg::ClsNumber;
        ModeStr, ModeChr:  close_r.token_class = tsc_pkg::ClsString;
        ModeSlash:         close_r.token_class = tsc_pkg::ClsOp;
        ModeCmt:           close_r.token_class = tsc_pkg::ClsComment;
        default: begin
          close_r.token_class = tsc_pkg::ClsText;
          close_r.span_length = 8'd0;
        end
      endcase
      mode_d   = ModeIdle;
      run_d    = '0;
      prefix_d = '0;
      esc_d    = 1'b0;
    end else begin
      unique case (mode_q) inside
        ModeText: begin
          if (!(c == ChSlash || c == ChDquote || c == ChSquote || is_alpha(c) ||
                is_digit(c) || is_op(c))) begin
            run_d = run_grow;
          end else begin
            close_v   = 1'b1;
            use_start = 1'b1;
          end
        end
        ModeWord: begin
          if (is_alpha(c) || is_digit(c) || c == ChUscore) begin
            if (run_q < RunKw) prefix_d[8*run_q[2:0] +: 8] = c;
            run_d = run_grow;
          end else begin
            close_v   = 1'b1;
            use_start = 1'b1;
            close_r.token_class = is_kw ? tsc_pkg::ClsKeyword :
                                  (c == ChParen) ? tsc_pkg::ClsFunc : tsc_pkg::ClsText;
          end
        end
        ModeNum: begin
          if (is_digit(c) || c == ChDot) begin
            run_d = run_grow;
          end else begin
            close_v   = 1'b1;
            use_start = 1'b1;
            close_r.token_class = tsc_pkg::ClsNumber;
          end
        end
        ModeStr, ModeChr: begin
          run_d = run_grow;
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (c == ChBslash) begin
            esc_d = 1'b1;
          end else if (c == ((mode_q == ModeStr) ? ChDquote : ChSquote)) begin
            close_v = 1'b1;
            close_r.token_class = tsc_pkg::ClsString;
            close_r.span_length = sat8(run_grow);
            mode_d   = ModeIdle;
            run_d    = '0;
            prefix_d = '0;
            esc_d    = 1'b0;
          end
        end
        ModeSlash: begin
          if (c == ChSlash) begin
            mode_d = ModeCmt;
            run_d  = run_grow;
          end else begin
            close_v   = 1'b1;
            use_start = 1'b1;
            close_r.token_class = tsc_pkg::ClsOp;
          end
        end
        ModeCmt: run_d = run_grow;
        default: use_start = 1'b1;
      endcase
    end

    if (use_start) begin
      mode_d   = st_mode;
      run_d    = st_op ? '0 : RUN_W'(1);
      prefix_d = is_alpha(c) ? {56'd0, c} : 64'd0;
      esc_d    = 1'b0;
    end

    op_r.token_class = tsc_pkg::ClsOp;
    op_r.span_length = 8'd1;
    op_r.line_done   = 1'b0;

    res0_o    = close_v ? close_r : op_r;
    res1_o    = op_r;
    res_cnt_o = {1'b0, close_v} + {1'b0, use_start & st_op};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      run_q    <= '0;
      prefix_q <= '0;
      esc_q    <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      run_q    <= run_d;
      prefix_q <= prefix_d;
      esc_q    <= esc_d;
    end
  end

  // end of line gives exactly one span, flagged as the last one
  a_line_end_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && line_end_i |-> res_cnt_o == 2'd1 && res0_o.line_done)
    else $error("line end did not give a single closing span");

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && line_end_i |=> mode_q == ModeIdle && run_q == '0 && !esc_q)
    else $error("lexer state not cleared after line end");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeIdle |-> run_q == '0 && prefix_q == 64'd0)
    else $error("idle lexer holds an open span");

endmodule

/* hdl/tsc_out_fifo.sv */
// ----------------------------------------------------------------------------
// tsc_out_fifo
// Small result queue: takes up to two spans per cycle, hands out one beat per
// cycle when not stalled; back pressure while fewer than two slots are free.
// ----------------------------------------------------------------------------
module tsc_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  tsc_pkg::tsc_result_t push0_i,
  input  tsc_pkg::tsc_result_t push1_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsc_pkg::tsc_result_t head_o
);

  localparam int unsigned PTR_W = $clog2(tsc_pkg::FifoDepth);
  localparam int unsigned CNT_W = $clog2(tsc_pkg::FifoDepth + 1);
  localparam logic [CNT_W-1:0] CntMax  = CNT_W'(tsc_pkg::FifoDepth);
  localparam logic [CNT_W-1:0] CntRoom = CNT_W'(tsc_pkg::FifoDepth - 2);

  tsc_pkg::tsc_result_t mem_q [tsc_pkg::FifoDepth];
  logic [PTR_W-1:0] rd_q, rd_d, wr_q, wr_d, wr_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign full_o      = cnt_q > CntRoom;
  assign wr_next     = wr_q + 1'b1;

  always_comb begin
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    wr_d  = wr_q + PTR_W'(push_cnt_i);
    cnt_d = cnt_q + CNT_W'(push_cnt_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q]    <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_next] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> ({1'b0, cnt_q} + (CNT_W + 1)'(push_cnt_i)) <= {1'b0, CntMax})
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != CntMax |-> PTR_W'(wr_q - rd_q) == PTR_W'(cnt_q))
    else $error("queue pointers disagree with fill count");

endmodule
